[hdl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Command and status codes, the key width and the link between cells.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int KEY_W = 32;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // What one cell hands to the cell above it.
   typedef struct packed {
      logic             shift;
      logic [KEY_W-1:0] key;
   } link_type;

endpackage

[hdl/skt_cell.sv]
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key chain
// Holds one key and its payload slot, compares against the current command
// key, and on an insert either keeps its entry, takes its lower neighbor's
// entry, or takes the new key.
// ----------------------------------------------------------------------------
module skt_cell #(
   parameter int INDEX  = 0,
   parameter int CNT_W  = 7,
   parameter int SLOT_W = 6
) (
   input  logic                         clock,
   input  logic [CNT_W-1:0]             count,
   input  logic [skt_pkg::KEY_W-1:0]    op_key,
   input  logic [SLOT_W-1:0]            new_slot,
   input  logic                         ins_commit,
   input  skt_pkg::link_type            left,
   input  logic [SLOT_W-1:0]            left_slot,
   output skt_pkg::link_type            right,
   output logic [SLOT_W-1:0]            slot,
   output logic                         match
);
   import skt_pkg::*;

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              occupied;
   logic              at_end;
   logic              own_shift;

   assign occupied  = CNT_W'(INDEX) < count;
   assign at_end    = CNT_W'(INDEX) == count;
   assign own_shift = occupied && (op_key < key_ff);
   assign match     = occupied && (op_key == key_ff);

   assign right.shift = own_shift;
   assign right.key   = key_ff;
   assign slot        = slot_ff;

   // Entries above the insert point move up by one; the insert point itself
   // is the first cell whose key is larger, or the first free cell.
   always_comb begin
      key_in  = key_ff;
      slot_in = slot_ff;
      if (ins_commit) begin
         if (left.shift) begin
            key_in  = left.key;
            slot_in = left_slot;
         end else if (own_shift || at_end) begin
            key_in  = op_key;
            slot_in = new_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      slot_ff <= slot_in;
   end

endmodule

[hdl/skt_payload_ram.sv]
// ----------------------------------------------------------------------------
// skt_payload_ram: payload storage by slot
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_payload_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sorted_key_table.sv]
// ----------------------------------------------------------------------------
// sorted_key_table: sorted key table built from a chain of key cells
// A taken request is registered, compared against all cells in the compare stage
// while the payload read is issued, then kept in the result stage and the output
// register. None is taken during a compare or while the result stage is stalled.
// Reset clears the entry count and the pipeline and sets the capacity to 64;
// no clearing pass is needed, so a request is taken right after reset.
// ----------------------------------------------------------------------------
module sorted_key_table #(
   parameter int DEPTH         = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = key[31:0], payload_in[63:32]; tuser = cmd[0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,
   // Result: tdata = payload_out[31:0], entry_count[38:32], zero[39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // Result: tuser = status[1:0]
   output logic [1:0]  rsp_tuser,
   // Capacity register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   import skt_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

   // Control and configuration
   logic [6:0]         cap_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               s1_ff, s2_ff;
   logic               s2_adv;
   logic               req_fire;

   // Command held for the compare cycle
   cmd_type            op_cmd_ff;
   logic [KEY_W-1:0]   op_key_ff;
   logic [31:0]        op_pay_ff;

   // Result of the compare cycle
   status_type         res_status_ff, res_status_in;
   logic [CNT_W-1:0]   res_count_ff;
   logic               res_hit_ff;

   // Output register
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [31:0]        rsp_pay_ff;
   logic [6:0]         rsp_count_ff;

   // Cell chain
   link_type           link   [DEPTH+1];
   logic [SLOT_W-1:0]  slot_w [DEPTH+1];
   logic [DEPTH-1:0]   match_vec;
   logic [SLOT_W-1:0]  hit_slot;
   logic               dup;
   logic               full;
   logic               ins_commit;
   logic [SLOT_W-1:0]  new_slot;
   logic [PAYLOAD_WIDTH-1:0] ram_q;

   assign csr_ready  = 1'b1;
   assign s2_adv     = s2_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_ff && (!s2_ff || s2_adv);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_cmd_ff <= cmd_type'(req_tuser);
         op_key_ff <= req_tdata[31:0];
         op_pay_ff <= req_tdata[63:32];
      end
   end

   // Cell zero sees no lower neighbor.
   assign link[0].shift = 1'b0;
   assign link[0].key   = '0;
   assign slot_w[0]     = '0;
   assign new_slot      = count_ff[SLOT_W-1:0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      skt_cell #(
         .INDEX  (i),
         .CNT_W  (CNT_W),
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock      (clock),
         .count      (count_ff),
         .op_key     (op_key_ff),
         .new_slot   (new_slot),
         .ins_commit (ins_commit),
         .left       (link[i]),
         .left_slot  (slot_w[i]),
         .right      (link[i+1]),
         .slot       (slot_w[i+1]),
         .match      (match_vec[i])
      );
   end

   // Keys are unique, so at most one cell matches and an OR picks its slot.
   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_slot = hit_slot | (slot_w[i+1] & {SLOT_W{match_vec[i]}});
      end
   end

   assign dup  = |match_vec;
   assign full = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || (count_ff == CNT_W'(DEPTH));
   assign ins_commit = s1_ff && (op_cmd_ff == CMD_INSERT) && !full && !dup;

   always_comb begin
      count_in = count_ff;
      if (ins_commit) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      unique case (op_cmd_ff)
         CMD_INSERT: begin
            if (full) begin
               res_status_in = STATUS_FULL;
            end else if (dup) begin
               res_status_in = STATUS_DUPLICATE;
            end else begin
               res_status_in = STATUS_OK;
            end
         end
         CMD_SEARCH: res_status_in = dup ? STATUS_OK : STATUS_NOT_FOUND;
         default:    res_status_in = STATUS_NOT_FOUND;
      endcase
   end

   skt_payload_ram #(
      .DEPTH  (DEPTH),
      .WIDTH  (PAYLOAD_WIDTH),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ins_commit),
      .wr_addr (new_slot),
      .wr_data (PAYLOAD_WIDTH'(op_pay_ff)),
      .rd_en   (s1_ff && (op_cmd_ff == CMD_SEARCH)),
      .rd_addr (hit_slot),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         s1_ff    <= req_fire;
         if (s1_ff) begin
            s2_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff) begin
         res_status_ff <= res_status_in;
         res_count_ff  <= count_in;
         res_hit_ff    <= (op_cmd_ff == CMD_SEARCH) && dup;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_status_ff <= res_status_ff;
         rsp_pay_ff    <= res_hit_ff ? 32'(ram_q) : 32'd0;
         rsp_count_ff  <= 7'(res_count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_pay_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      s1_ff |=> s2_ff)
      else $error("compared command did not reach the result stage");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ins_commit |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not raise the entry count by one");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !ins_commit |=> $stable(count_ff))
      else $error("entry count changed without an insert");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> !req_tready)
      else $error("request taken while a command is being compared");
`endif

endmodule
